>>> hdl/fpb_pkg.sv
// Shared types, character codes and status codes for the FEN placement parser.
// No dependencies; every other file imports this package.
package fpb_pkg;

    localparam int unsigned NUM_BOARDS = 8;
    localparam int unsigned BOARD_W    = 64;
    localparam int unsigned CH_W       = 8;
    localparam int unsigned IDX_W      = 4;
    localparam int unsigned OUT_DATA_W = 520;   // 8 boards + status, padded to bytes
    localparam int unsigned OUT_PAD_W  = OUT_DATA_W - NUM_BOARDS * BOARD_W - 2;

    // board slots in the result word, lowest first
    localparam int unsigned BD_WHITE = 0;
    localparam int unsigned BD_BLACK = 1;

    localparam logic [IDX_W-1:0] ROWS    = 4'd8;
    localparam logic [IDX_W-1:0] COLS    = 4'd8;
    localparam logic [IDX_W-1:0] COL_SAT = 4'd9;

    localparam logic [CH_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [CH_W-1:0] CH_SLASH    = 8'h2F;
    localparam logic [CH_W-1:0] CH_ZERO     = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE     = 8'h39;
    localparam logic [CH_W-1:0] CH_UPPER_A  = 8'h41;
    localparam logic [CH_W-1:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [CH_W-1:0] CH_CASE_OFS = 8'h20;
    localparam logic [CH_W-1:0] CH_PAWN     = 8'h70;  // 'p'
    localparam logic [CH_W-1:0] CH_KNIGHT   = 8'h6E;  // 'n'
    localparam logic [CH_W-1:0] CH_BISHOP   = 8'h62;  // 'b'
    localparam logic [CH_W-1:0] CH_ROOK     = 8'h72;  // 'r'
    localparam logic [CH_W-1:0] CH_QUEEN    = 8'h71;  // 'q'
    localparam logic [CH_W-1:0] CH_KING     = 8'h6B;  // 'k'

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_PIECE = 2'd1,
        ST_BAD_COLS  = 2'd2,
        ST_FEW_ROWS  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CK_SPACE,
        CK_SLASH,
        CK_DIGIT,
        CK_PIECE,
        CK_OTHER
    } t_ch_kind;

    // encoding equals the piece board slot in the result word
    typedef enum logic [2:0] {
        PC_PAWN   = 3'd2,
        PC_KNIGHT = 3'd3,
        PC_BISHOP = 3'd4,
        PC_ROOK   = 3'd5,
        PC_QUEEN  = 3'd6,
        PC_KING   = 3'd7
    } t_piece;

    typedef logic [BOARD_W-1:0]                  t_board;
    typedef logic [NUM_BOARDS-1:0][BOARD_W-1:0]  t_board_set;

    typedef struct packed {
        t_ch_kind          kind;
        t_piece            piece;
        logic              white;
        logic [IDX_W-1:0]  digit;
    } t_ch_info;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            first;
        logic            last;
    } t_item;

    function automatic t_status keep_first(t_status cur, t_status code);
        return (cur == ST_OK) ? code : cur;
    endfunction

endpackage

>>> hdl/fpb_decode.sv
// Character classifier: sorts one ASCII character into space, slash, digit,
// piece letter or unknown. Depends on fpb_pkg.
module fpb_decode (
    input  logic [fpb_pkg::CH_W-1:0] i_ch,
    output fpb_pkg::t_ch_info        o_info
);
    import fpb_pkg::*;

    logic            upper;
    logic [CH_W-1:0] low;

    always_comb begin
        upper = (i_ch >= CH_UPPER_A) && (i_ch <= CH_UPPER_Z);
        low   = upper ? i_ch + CH_CASE_OFS : i_ch;

        o_info.kind  = CK_OTHER;
        o_info.piece = PC_PAWN;
        o_info.white = upper;
        o_info.digit = IDX_W'(i_ch - CH_ZERO);

        if (i_ch == CH_SPACE) begin
            o_info.kind = CK_SPACE;
        end else if (i_ch == CH_SLASH) begin
            o_info.kind = CK_SLASH;
        end else if (i_ch inside {[CH_ZERO:CH_NINE]}) begin
            o_info.kind = CK_DIGIT;
        end else begin
            o_info.kind = CK_PIECE;
            case (low)
                CH_PAWN:   o_info.piece = PC_PAWN;
                CH_KNIGHT: o_info.piece = PC_KNIGHT;
                CH_BISHOP: o_info.piece = PC_BISHOP;
                CH_ROOK:   o_info.piece = PC_ROOK;
                CH_QUEEN:  o_info.piece = PC_QUEEN;
                CH_KING:   o_info.piece = PC_KING;
                default:   o_info.kind  = CK_OTHER;
            endcase
        end
    end

endmodule

>>> hdl/fpb_state.sv
// Parser state (boards, row and column pointers, first error, done flag) and
// the single-step update for one character. Depends on fpb_pkg, fpb_decode.
module fpb_state (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  fpb_pkg::t_item      i_item,
    output logic                o_emit,
    output fpb_pkg::t_board_set o_boards,
    output fpb_pkg::t_status    o_status
);
    import fpb_pkg::*;

    t_ch_info info;

    t_board_set       r_boards, n_boards;
    logic [IDX_W-1:0] r_row, n_row;
    logic [IDX_W-1:0] r_col, n_col;
    t_status          r_err, n_err;
    logic             r_done, n_done;

    logic             finish;
    logic [IDX_W:0]   col_sum;
    t_board           sq_mask;
    logic [NUM_BOARDS-1:0] sel;

    fpb_decode u_decode (
        .i_ch   (i_item.ch),
        .o_info (info)
    );

    // board select: colour board plus the piece board
    always_comb begin
        for (int i = 0; i < NUM_BOARDS; i++) begin
            if (i == BD_WHITE) begin
                sel[i] = info.white;
            end else if (i == BD_BLACK) begin
                sel[i] = !info.white;
            end else begin
                sel[i] = (info.piece == t_piece'(3'(i)));
            end
        end
    end

    always_comb begin
        n_boards = r_boards;
        n_row    = r_row;
        n_col    = r_col;
        n_err    = r_err;
        n_done   = r_done;
        finish   = 1'b0;
        col_sum  = '0;
        sq_mask  = '0;

        if (i_item.first) begin
            n_boards = '0;
            n_row    = '0;
            n_col    = '0;
            n_err    = ST_OK;
            n_done   = 1'b0;
        end

        if (!n_done) begin
            if (info.kind == CK_SPACE) begin
                finish = 1'b1;
            end else begin
                if (n_row < ROWS) begin
                    case (info.kind)
                        CK_SLASH: begin
                            if (n_col != COLS) begin
                                n_err = keep_first(n_err, ST_BAD_COLS);
                            end
                            n_row = n_row + 1'b1;
                            n_col = '0;
                        end
                        CK_DIGIT: begin
                            col_sum = {1'b0, n_col} + {1'b0, info.digit};
                            n_col   = (col_sum > {1'b0, COL_SAT}) ? COL_SAT : col_sum[IDX_W-1:0];
                        end
                        CK_PIECE: begin
                            if (n_col < COLS) begin
                                // square (7-row)*8 + (7-col)
                                sq_mask = t_board'(1) << (~{n_row[2:0], n_col[2:0]});
                                for (int i = 0; i < NUM_BOARDS; i++) begin
                                    if (sel[i]) begin
                                        n_boards[i] = n_boards[i] | sq_mask;
                                    end
                                end
                            end
                            n_col = (n_col >= COL_SAT) ? COL_SAT : n_col + 1'b1;
                        end
                        CK_OTHER: begin
                            n_err = keep_first(n_err, ST_BAD_PIECE);
                        end
                        default: ;
                    endcase
                end
                finish = i_item.last;
            end

            if (finish) begin
                if ((n_row < ROWS) && (n_col != COLS)) begin
                    n_err = keep_first(n_err, ST_BAD_COLS);
                end
                if (n_row < ROWS - 1'b1) begin
                    n_err = keep_first(n_err, ST_FEW_ROWS);
                end
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boards <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_err    <= ST_OK;
            r_done   <= 1'b0;
        end else if (i_step) begin
            r_boards <= n_boards;
            r_row    <= n_row;
            r_col    <= n_col;
            r_err    <= n_err;
            r_done   <= n_done;
        end
    end

    assign o_emit   = finish;
    assign o_boards = n_boards;
    assign o_status = n_err;

endmodule

>>> hdl/fen_placement_to_bitboards.sv
// Top level of the FEN piece-placement parser: input register, parser state
// and result register with the stream handshakes. Depends on fpb_pkg, fpb_state.
//
// One character is taken per clock, back to back, with no bubbles: a word
// enters the input register, is decoded and folded into the boards when it
// steps out of that register, and when it ends the placement field (space or
// tlast) the eight boards and the status are loaded into the result register
// in that same step, and the result word is offered from there. The result
// register holds a finished word until it is taken, while one further
// character can enter the input register; input stalls only when the result
// register is full and not being taken. tuser[0] starts a new string and clears all boards.
module fen_placement_to_bitboards (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [fpb_pkg::CH_W-1:0]        i_s_tdata,   // [7:0] ch
    input  logic                            i_s_tlast,   // last_char
    input  logic [0:0]                      i_s_tuser,   // [0] first_char
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [63:0] white, [127:64] black, [191:128] pawn, [255:192] knight,
    // [319:256] bishop, [383:320] rook, [447:384] queen, [511:448] king,
    // [513:512] status, rest zero
    output logic [fpb_pkg::OUT_DATA_W-1:0]  o_m_tdata
);
    import fpb_pkg::*;

    logic       r_in_valid;
    t_item      r_item;
    logic       r_out_valid;
    t_board_set r_boards;
    t_status    r_status;

    logic       adv;
    logic       step;
    logic       emit;
    t_board_set boards;
    t_status    status;

    assign adv        = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && adv;
    assign o_s_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item.ch    <= i_s_tdata;
            r_item.first <= i_s_tuser[0];
            r_item.last  <= i_s_tlast;
        end
    end

    fpb_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_item),
        .o_emit   (emit),
        .o_boards (boards),
        .o_status (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= step && emit;
        end
    end

    // load the result word only when a field closes
    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_boards <= boards;
            r_status <= status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{OUT_PAD_W{1'b0}}, r_status, r_boards};

endmodule
